@@ sv/prr_pkg.sv @@
package prr_pkg;

   localparam int SLOTS_DEF     = 64;
   localparam int MAX_LEVEL_DEF = 15;

   // fixed field widths on the ports
   localparam int SLOT_FW  = 6;
   localparam int LEVEL_FW = 4;
   localparam int REQ_DW   = 16;
   localparam int RSP_DW   = 16;

   // request kinds carried on req_tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_PICK  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PASS1 = 4'b0010,
      ST_PASS2 = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   // slot table strobes
   typedef struct packed {
      logic wr_en;
      logic clr_en;
      logic rd_en;
   } tbl_ctl_type;

endpackage

@@ sv/prr_slot_table.sv @@
module prr_slot_table #(
   parameter int SLOTS     = prr_pkg::SLOTS_DEF,
   parameter int MAX_LEVEL = prr_pkg::MAX_LEVEL_DEF,
   localparam int SW = $clog2(SLOTS),
   localparam int LW = $clog2(MAX_LEVEL + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  prr_pkg::tbl_ctl_type ctl,
   input  logic [SW-1:0]       wr_addr,
   input  logic                wr_run,
   input  logic [LW-1:0]       wr_lvl,
   input  logic [SW-1:0]       clr_addr,
   input  logic [SW-1:0]       rd_addr,
   output logic                rd_run,
   output logic [LW-1:0]       rd_lvl
);

   // runnable flags in flops so reset clears them at once
   logic [SLOTS-1:0] run_ff;
   // level store, read back together with the runnable flag of the same slot
   logic [LW-1:0]    lvl_mem [SLOTS];
   logic             rd_run_ff;
   logic [LW-1:0]    rd_lvl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         if (ctl.wr_en) begin
            run_ff[wr_addr] <= wr_run;
         end
         if (ctl.clr_en) begin
            run_ff[clr_addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         lvl_mem[wr_addr] <= wr_lvl;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_lvl_ff <= lvl_mem[rd_addr];
         rd_run_ff <= run_ff[rd_addr];
      end
   end

   assign rd_run = rd_run_ff;
   assign rd_lvl = rd_lvl_ff;

endmodule

@@ sv/priority_round_robin_scheduler.sv @@
// channel | dir | tdata (low bit up)                          | tuser
// --------+-----+---------------------------------------------+-----------------
// req_    | in  | slot[5:0] runnable[6] level[10:7], zero pad | operation
// rsp_    | out | chosen_slot[5:0] chosen_level[9:6], zero pad| granted
//
// a write request answers on the next cycle
// a pick request walks the slot table twice through one registered read
// port, with a less-than level comparator in pass one and an equal one
// in pass two
// req_tready is high only when idle; a response holds until rsp_tready
// synchronous reset clears runnable flags and level cursors at once
module priority_round_robin_scheduler #(
   parameter int SLOTS     = prr_pkg::SLOTS_DEF,
   parameter int MAX_LEVEL = prr_pkg::MAX_LEVEL_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [prr_pkg::REQ_DW-1:0]  req_tdata,  // slot, runnable, level
   input  logic                        req_tuser,  // operation
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [prr_pkg::RSP_DW-1:0]  rsp_tdata,  // chosen_slot, chosen_level
   output logic                        rsp_tuser   // granted
);

   localparam int SW  = $clog2(SLOTS);
   localparam int LW  = $clog2(MAX_LEVEL + 1);
   localparam int CW  = SW + prr_pkg::SLOT_FW;   // wide enough for both slot forms
   localparam int LCW = LW + prr_pkg::LEVEL_FW;  // wide enough for both level forms

   prr_pkg::state_type   state_ff, state_in;
   prr_pkg::tbl_ctl_type tbl_ctl;

   logic [SW-1:0] ptr_ff, ptr_in;     // table read pointer, wraps at SLOTS
   logic [SW-1:0] cnt_ff, cnt_in;     // reads issued in this pass
   logic          issue_ff, issue_in;
   logic          found_ff, found_in;
   logic [LW-1:0] top_ff, top_in;     // most urgent level seen
   logic [SW-1:0] pick_ff, pick_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [SW-1:0] rd_idx_ff, rd_idx_in;

   logic                         rsp_granted_ff, rsp_granted_in;
   logic [prr_pkg::SLOT_FW-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [prr_pkg::LEVEL_FW-1:0] rsp_level_ff, rsp_level_in;

   // per-level round-robin cursors
   logic [SW-1:0] cur_ff [MAX_LEVEL+1];
   logic          cur_wr_en;
   logic [SW-1:0] cur_wr_val;

   // request fields
   logic                         req_op;
   logic [prr_pkg::SLOT_FW-1:0]  req_slot;
   logic                         req_run;
   logic [prr_pkg::LEVEL_FW-1:0] req_level;
   logic                         req_acc;

   logic [CW-1:0]  slot_ext;
   logic           slot_ok;
   logic [SW-1:0]  wr_addr;
   logic [LCW-1:0] lvl_ext;
   logic [LW-1:0]  wr_lvl;

   logic          rd_run;
   logic [LW-1:0] rd_lvl;
   logic          lvl_lt, lvl_eq;
   logic [SW-1:0] ptr_nxt;
   logic [SW-1:0] pick_nxt;
   logic          pass_done;

   assign req_op    = req_tuser;
   assign req_slot  = req_tdata[5:0];
   assign req_run   = req_tdata[6];
   assign req_level = req_tdata[10:7];
   assign req_acc   = req_tvalid && req_tready;

   // out of range slots are dropped, high levels saturate
   assign slot_ext = CW'(req_slot);
   assign slot_ok  = slot_ext < CW'(SLOTS);
   assign wr_addr  = slot_ext[SW-1:0];
   assign lvl_ext  = LCW'(req_level);
   assign wr_lvl   = (lvl_ext > LCW'(MAX_LEVEL)) ? LW'(MAX_LEVEL) : lvl_ext[LW-1:0];

   prr_slot_table #(
      .SLOTS     (SLOTS),
      .MAX_LEVEL (MAX_LEVEL)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tbl_ctl),
      .wr_addr  (wr_addr),
      .wr_run   (req_run),
      .wr_lvl   (wr_lvl),
      .clr_addr (pick_ff),
      .rd_addr  (ptr_ff),
      .rd_run   (rd_run),
      .rd_lvl   (rd_lvl)
   );

   // the level comparators: less-than in pass one, equal in pass two
   assign lvl_lt = rd_lvl < top_ff;
   assign lvl_eq = rd_lvl == top_ff;

   assign ptr_nxt   = (ptr_ff == SW'(SLOTS - 1)) ? '0 : ptr_ff + 1'b1;
   assign pick_nxt  = (pick_ff == SW'(SLOTS - 1)) ? '0 : pick_ff + 1'b1;
   assign pass_done = !issue_ff && !rd_vld_ff;

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      cnt_in         = cnt_ff;
      issue_in       = issue_ff;
      found_in       = found_ff;
      top_in         = top_ff;
      pick_in        = pick_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = ptr_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_level_in   = rsp_level_ff;
      tbl_ctl        = '0;
      cur_wr_en      = 1'b0;
      cur_wr_val     = pick_nxt;

      // walk the table one entry a cycle during either pass
      if (((state_ff == prr_pkg::ST_PASS1) || (state_ff == prr_pkg::ST_PASS2)) && issue_ff) begin
         tbl_ctl.rd_en = 1'b1;
         rd_vld_in     = 1'b1;
         ptr_in        = ptr_nxt;
         cnt_in        = cnt_ff + 1'b1;
         if (cnt_ff == SW'(SLOTS - 1)) begin
            issue_in = 1'b0;
         end
      end

      case (state_ff)
         prr_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_op == prr_pkg::OP_PICK) begin
                  state_in = prr_pkg::ST_PASS1;
                  ptr_in   = '0;
                  cnt_in   = '0;
                  issue_in = 1'b1;
                  found_in = 1'b0;
                  top_in   = LW'(MAX_LEVEL);
               end else begin
                  tbl_ctl.wr_en  = slot_ok;
                  rsp_granted_in = 1'b0;
                  rsp_slot_in    = '0;
                  rsp_level_in   = '0;
                  state_in       = prr_pkg::ST_RESP;
               end
            end
         end
         prr_pkg::ST_PASS1: begin
            // lowest level among runnable slots
            if (rd_vld_ff && rd_run && (!found_ff || lvl_lt)) begin
               top_in   = rd_lvl;
               found_in = 1'b1;
            end
            if (pass_done) begin
               if (found_ff) begin
                  state_in = prr_pkg::ST_PASS2;
                  ptr_in   = cur_ff[top_ff];
                  cnt_in   = '0;
                  issue_in = 1'b1;
                  found_in = 1'b0;
               end else begin
                  rsp_granted_in = 1'b0;
                  rsp_slot_in    = '0;
                  rsp_level_in   = '0;
                  state_in       = prr_pkg::ST_RESP;
               end
            end
         end
         prr_pkg::ST_PASS2: begin
            // first runnable slot at that level from the cursor on
            if (rd_vld_ff && rd_run && lvl_eq && !found_ff) begin
               found_in = 1'b1;
               pick_in  = rd_idx_ff;
               issue_in = 1'b0;
            end
            if (pass_done) begin
               if (found_ff) begin
                  tbl_ctl.clr_en = 1'b1;
                  cur_wr_en      = 1'b1;
                  rsp_granted_in = 1'b1;
                  rsp_slot_in    = prr_pkg::SLOT_FW'(pick_ff);
                  rsp_level_in   = prr_pkg::LEVEL_FW'(top_ff);
               end else begin
                  rsp_granted_in = 1'b0;
                  rsp_slot_in    = '0;
                  rsp_level_in   = '0;
               end
               state_in = prr_pkg::ST_RESP;
            end
         end
         prr_pkg::ST_RESP: begin
            if (rsp_tready) begin
               state_in = prr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= prr_pkg::ST_IDLE;
         issue_ff  <= 1'b0;
         found_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issue_ff  <= issue_in;
         found_ff  <= found_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      cnt_ff         <= cnt_in;
      top_ff         <= top_in;
      pick_ff        <= pick_in;
      rd_idx_ff      <= rd_idx_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_level_ff   <= rsp_level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= MAX_LEVEL; i++) begin
            cur_ff[i] <= '0;
         end
      end else if (cur_wr_en) begin
         cur_ff[top_ff] <= cur_wr_val;
      end
   end

   assign req_tready = (state_ff == prr_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == prr_pkg::ST_RESP);
   assign rsp_tuser  = rsp_granted_ff;
   assign rsp_tdata  = prr_pkg::RSP_DW'({rsp_level_ff, rsp_slot_ff});

   // one request in flight: never ready while a response is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a response is pending");

   // a response without a grant carries all-zero data
   a_zero_nogrant: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("non-grant response carries data");

   // table read data only arrives during a scan
   a_rd_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ((state_ff == prr_pkg::ST_PASS1) || (state_ff == prr_pkg::ST_PASS2)))
      else $error("table read outside a scan");

   // the level under search stays within range through pass two
   a_top_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == prr_pkg::ST_PASS2) |-> (LCW'(top_ff) <= LCW'(MAX_LEVEL)))
      else $error("searched level out of range");

endmodule
